>>> rtl/accumulator_machine_step_assert.svh
// Assertion macros for the RTL, used by the controller.
// Compile with ASSERT_OFF defined to drop every assertion.
`ifndef ACCUMULATOR_MACHINE_STEP_ASSERT_SVH
`define ACCUMULATOR_MACHINE_STEP_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked at every clock edge outside reset.
`define AMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define AMS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define AMS_ASSERT(label, prop, msg)
`define AMS_ASSERT_RST(label, prop, msg)

`endif

`endif

>>> rtl/ams_pkg.sv
package ams_pkg;

    localparam int WORD_W   = 15;
    localparam int PC_W     = 7;
    localparam int WORD_MAX = 9999;

    // floor(x / 100) as (x * 5243) >> 19, exact for x below 10000
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  RADIX        = 7'd100;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [6:0] OP_READ   = 7'd10;
    localparam logic [6:0] OP_WRITE  = 7'd11;
    localparam logic [6:0] OP_LOAD   = 7'd20;
    localparam logic [6:0] OP_STORE  = 7'd21;
    localparam logic [6:0] OP_ADD    = 7'd30;
    localparam logic [6:0] OP_SUB    = 7'd31;
    localparam logic [6:0] OP_DIV    = 7'd32;
    localparam logic [6:0] OP_MUL    = 7'd33;
    localparam logic [6:0] OP_BRANCH = 7'd40;
    localparam logic [6:0] OP_BRNEG  = 7'd41;
    localparam logic [6:0] OP_BRZERO = 7'd42;
    localparam logic [6:0] OP_HALT   = 7'd43;

    typedef enum logic [2:0] {
        EV_DONE,
        EV_WRITE,
        EV_HALT,
        EV_DIVZ,
        EV_BADOP,
        EV_OVF,
        EV_STOPPED
    } t_event;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_FETCH,
        S_DECODE,
        S_SPLIT,
        S_OPRD,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic decode;
        logic split;
        logic oprd;
        logic exec;
        logic mul_fin;
        logic div_fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cmd_step;
        logic stopped;
        logic ip_oob;
        logic op_mul;
        logic op_div;
        logic div_done;
    } t_sts;

endpackage

>>> rtl/ams_ram.sv
module ams_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

>>> rtl/ams_div.sv
module ams_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ams_pkg::WORD_W-1:0]  i_dividend,
    input  logic signed [ams_pkg::WORD_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic signed [ams_pkg::WORD_W-1:0]  o_quotient
);

    import ams_pkg::*;

    localparam int MAG_W = WORD_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [MAG_W-1:0] r_num;
    logic [MAG_W-1:0] r_den;
    logic [MAG_W-1:0] r_rem;

    logic [WORD_W-1:0] num_abs;
    logic [WORD_W-1:0] den_abs;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W:0]   diff;
    logic              ge;

    assign num_abs = i_dividend[WORD_W-1] ? WORD_W'(-i_dividend) : i_dividend;
    assign den_abs = i_divisor[WORD_W-1]  ? WORD_W'(-i_divisor)  : i_divisor;
    assign shifted = {r_rem, r_num[MAG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign ge      = !diff[WORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit a cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
            r_num <= num_abs[MAG_W-1:0];
            r_den <= den_abs[MAG_W-1:0];
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            r_num <= {r_num[MAG_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? WORD_W'(-{1'b0, r_num}) : {1'b0, r_num};

endmodule

>>> rtl/ams_ctrl.sv
`include "accumulator_machine_step_assert.svh"

module ams_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ams_pkg::t_cmd o_cmd,
    input  ams_pkg::t_sts i_sts
);

    import ams_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.cmd_step == CMD_LOAD) begin
                        n_state = S_LOAD;
                    end else if (i_sts.stopped || i_sts.ip_oob) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_LOAD:   n_state = S_DONE;
            S_FETCH:  n_state = S_DECODE;
            S_DECODE: n_state = S_SPLIT;
            S_SPLIT:  n_state = S_OPRD;
            S_OPRD:   n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.op_mul) begin
                    n_state = S_MUL;
                end else if (i_sts.op_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: n_state = S_DONE;
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = accept;
        o_cmd.load_wr  = (r_state == S_LOAD);
        o_cmd.decode   = (r_state == S_DECODE);
        o_cmd.split    = (r_state == S_SPLIT);
        o_cmd.oprd     = (r_state == S_OPRD);
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.mul_fin  = (r_state == S_MUL);
        o_cmd.div_fin  = (r_state == S_DIV) && i_sts.div_done;
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `AMS_ASSERT(a_accept_leaves_idle, (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE), "item accepted but controller stayed idle")
    `AMS_ASSERT(a_result_waits, (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE), "finished result dropped while output stalled")
    `AMS_ASSERT(a_div_done_in_wait, i_sts.div_done |-> (r_state == S_DIV), "divider finished outside its wait state")
    `AMS_ASSERT_RST(a_reset_clears, !i_rst_n |=> (!o_out_valid && r_state == S_IDLE), "reset left output or state busy")

endmodule

>>> rtl/ams_dpath.sv
module ams_dpath #(
    parameter int STORE_WORDS = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ams_pkg::t_cmd                     i_cmd,
    output ams_pkg::t_sts                     o_sts,
    input  logic                              i_command,
    input  logic [ams_pkg::PC_W-1:0]          i_address,
    input  logic signed [ams_pkg::WORD_W-1:0] i_word,
    output logic [2:0]                        o_event_res,
    output logic signed [ams_pkg::WORD_W-1:0] o_value,
    output logic [ams_pkg::PC_W-1:0]          o_program_counter
);

    import ams_pkg::*;

    localparam int               AW     = $clog2(STORE_WORDS);
    localparam int               MAG_W  = WORD_W - 1;
    localparam int               QP_W   = MAG_W + 13;
    localparam logic [PC_W-1:0]  SW_LIM = PC_W'(STORE_WORDS);
    localparam logic signed [30:0] SAT_HI = 31'(WORD_MAX);
    localparam logic signed [30:0] SAT_LO = -SAT_HI;

    function automatic logic signed [WORD_W-1:0] sat(input logic signed [30:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = WORD_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = WORD_W'(SAT_LO);
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic oor(input logic signed [30:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    // architectural state
    logic signed [WORD_W-1:0] r_acc;
    logic [PC_W-1:0]          r_ip;
    logic                     r_stopped;
    logic [STORE_WORDS-1:0]   r_vld;

    // item and working registers
    logic [PC_W-1:0]          r_addr;
    logic signed [WORD_W-1:0] r_word;
    logic                     r_rd_ok;
    logic [MAG_W-1:0]         r_mag;
    logic [PC_W-1:0]          r_opc;
    logic [PC_W-1:0]          r_opd;
    logic signed [WORD_W-1:0] r_m;
    logic signed [2*WORD_W-1:0] r_prod;
    t_event                   r_event;

    // output register
    t_event                   r_o_event;
    logic signed [WORD_W-1:0] r_o_value;
    logic [PC_W-1:0]          r_o_pc;

    logic signed [WORD_W-1:0] ram_q;
    logic [PC_W-1:0]          rd_addr;
    logic                     rd_inr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [WORD_W-1:0] wr_data;
    logic signed [WORD_W-1:0] ins;
    logic [WORD_W-1:0]        ins_abs;
    logic [QP_W-1:0]          q_prod;
    logic [MAG_W-1:0]         rem;
    logic signed [WORD_W-1:0] m;
    logic                     opd_inr;
    logic signed [WORD_W:0]   sum;
    logic signed [WORD_W:0]   dif;
    logic                     div_go;
    logic                     div_done;
    logic signed [WORD_W-1:0] quotient;

    logic signed [WORD_W-1:0] ex_acc;
    logic [PC_W-1:0]          ex_ip;
    logic                     ex_stop;
    t_event                   ex_event;
    logic                     ex_wr;
    logic signed [WORD_W-1:0] ex_wdata;

    assign rd_addr = i_cmd.oprd ? r_opd : r_ip;
    assign rd_inr  = rd_addr < SW_LIM;
    assign opd_inr = r_opd < SW_LIM;

    assign ins     = r_rd_ok ? ram_q : '0;
    assign ins_abs = ins[WORD_W-1] ? WORD_W'(-ins) : ins;
    assign q_prod  = {13'd0, ins_abs[MAG_W-1:0]} * QP_W'(DIV100_MUL);
    assign rem     = r_mag - ({7'd0, r_opc} * MAG_W'(RADIX));

    assign m      = r_rd_ok ? ram_q : '0;
    assign sum    = {r_acc[WORD_W-1], r_acc} + {m[WORD_W-1], m};
    assign dif    = {r_acc[WORD_W-1], r_acc} - {m[WORD_W-1], m};
    assign div_go = (r_opc == OP_DIV) && (m != '0);

    always_comb begin
        ex_acc   = r_acc;
        ex_ip    = PC_W'(r_ip + 1'b1);
        ex_stop  = 1'b0;
        ex_event = EV_DONE;
        ex_wr    = 1'b0;
        ex_wdata = r_word;
        unique case (r_opc)
            OP_READ: begin
                ex_wr = 1'b1;
            end
            OP_WRITE: begin
                ex_event = EV_WRITE;
            end
            OP_LOAD: begin
                ex_acc = m;
            end
            OP_STORE: begin
                ex_wr    = 1'b1;
                ex_wdata = r_acc;
            end
            OP_ADD: begin
                ex_acc = sat(31'(sum));
                if (oor(31'(sum))) begin
                    ex_event = EV_OVF;
                end
            end
            OP_SUB: begin
                ex_acc = sat(31'(dif));
                if (oor(31'(dif))) begin
                    ex_event = EV_OVF;
                end
            end
            OP_DIV: begin
                if (m == '0) begin
                    ex_stop  = 1'b1;
                    ex_event = EV_DIVZ;
                    ex_ip    = r_ip;
                end
            end
            OP_MUL: begin
                // finished in the next cycle from the product register
            end
            OP_BRANCH: begin
                ex_ip = r_opd;
            end
            OP_BRNEG: begin
                if (r_acc[WORD_W-1]) begin
                    ex_ip = r_opd;
                end
            end
            OP_BRZERO: begin
                if (r_acc == '0) begin
                    ex_ip = r_opd;
                end
            end
            OP_HALT: begin
                ex_stop  = 1'b1;
                ex_event = EV_HALT;
                ex_ip    = r_ip;
            end
            default: begin
                ex_stop  = 1'b1;
                ex_event = EV_BADOP;
                ex_ip    = r_ip;
            end
        endcase
    end

    assign wr_en   = (i_cmd.load_wr && (r_addr < SW_LIM)) ||
                     (i_cmd.exec && ex_wr && opd_inr);
    assign wr_addr = i_cmd.load_wr ? r_addr[AW-1:0] : r_opd[AW-1:0];
    assign wr_data = i_cmd.load_wr ? r_word : ex_wdata;

    ams_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr[AW-1:0]),
        .o_rd_data (ram_q)
    );

    ams_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.exec && div_go),
        .i_dividend (r_acc),
        .i_divisor  (m),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_ip      <= '0;
            r_stopped <= 1'b0;
            r_vld     <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            // an entry never written reads as zero
            r_rd_ok <= rd_inr && r_vld[rd_addr[AW-1:0]];
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.capture && (i_command == CMD_STEP) && !r_stopped &&
                !(r_ip < SW_LIM)) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_acc <= ex_acc;
                r_ip  <= ex_ip;
                if (ex_stop) begin
                    r_stopped <= 1'b1;
                end
            end
            if (i_cmd.mul_fin) begin
                r_acc <= sat(31'(r_prod));
            end
            if (i_cmd.div_fin) begin
                r_acc <= quotient;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_address;
            r_word <= sat(31'(i_word));
            if (i_command == CMD_STEP && r_stopped) begin
                r_event <= EV_STOPPED;
            end else if (i_command == CMD_STEP && !(r_ip < SW_LIM)) begin
                r_event <= EV_HALT;
            end else begin
                r_event <= EV_DONE;
            end
        end
        if (i_cmd.decode) begin
            r_mag <= ins_abs[MAG_W-1:0];
            r_opc <= q_prod[DIV100_SHIFT +: PC_W];
        end
        if (i_cmd.split) begin
            r_opd <= rem[PC_W-1:0];
        end
        if (i_cmd.exec) begin
            r_m     <= m;
            r_prod  <= (2*WORD_W)'(r_acc) * (2*WORD_W)'(m);
            r_event <= ex_event;
        end
        if (i_cmd.mul_fin && oor(31'(r_prod))) begin
            r_event <= EV_OVF;
        end
        if (i_cmd.out_load) begin
            r_o_event <= r_event;
            r_o_value <= (r_event == EV_WRITE) ? r_m : r_acc;
            r_o_pc    <= r_ip;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.cmd_step = i_command;
        o_sts.stopped  = r_stopped;
        o_sts.ip_oob   = !(r_ip < SW_LIM);
        o_sts.op_mul   = (r_opc == OP_MUL);
        o_sts.op_div   = div_go;
        o_sts.div_done = div_done;
    end

    assign o_event_res       = r_o_event;
    assign o_value           = r_o_value;
    assign o_program_counter = r_o_pc;

endmodule

>>> rtl/accumulator_machine_step.sv
// Decimal accumulator machine, one item per load or instruction step.
// Input channel: i_in_valid / o_in_stall with i_command, i_address, i_word.
//   A load item (command 0) writes the clamped word into the store at
//   i_address; a step item (command 1) runs the instruction at the pointer.
// Output channel: o_out_valid / i_out_stall with one result per item:
//   o_event_res, o_value (written word or accumulator) and o_program_counter.
// Path from acceptance to the output register: a load goes through S_LOAD, a step
// on a stopped machine or past the end straight to S_DONE, most instructions through
// S_FETCH, S_DECODE, S_SPLIT, S_OPRD and S_EXEC, multiply adds S_MUL and divide waits
// in S_DIV on the restoring divider, one quotient bit per cycle. The other steps follow
// the single store port (instruction fetch, then operand read) and the decode of opcode and operand.
// One item is in work at a time; the next is accepted in the cycle after the
// result enters the output register.
// A result stalled at the output waits in the output register while the next
// item is taken and worked on; that item's result waits until the output frees.
// Reset (synchronous, active low) clears the accumulator, pointer and stopped
// flag, and marks every store word as zero through per-word valid bits, so
// the block is ready in the first cycle after reset.
module accumulator_machine_step #(
    parameter int STORE_WORDS = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [ams_pkg::PC_W-1:0]          i_address,
    input  logic signed [ams_pkg::WORD_W-1:0] i_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_event_res,
    output logic signed [ams_pkg::WORD_W-1:0] o_value,
    output logic [ams_pkg::PC_W-1:0]          o_program_counter
);

    import ams_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ams_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ams_dpath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_command         (i_command),
        .i_address         (i_address),
        .i_word            (i_word),
        .o_event_res       (o_event_res),
        .o_value           (o_value),
        .o_program_counter (o_program_counter)
    );

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ams_pkg::*;

    localparam int STORE_WORDS    = 100;
    localparam int TOP_PC         = 88;    // keep the pointer below this so it never runs off
    localparam int RANDOM_ITEMS   = 550;
    localparam int PHASE_ITEMS    = 70;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct {
        t_event                    ev;
        logic signed [WORD_W-1:0]  value;
        logic [PC_W-1:0]           pc;
    } machine_result_t;

    typedef struct {
        logic                      cmd;
        logic [PC_W-1:0]           addr;
        logic signed [WORD_W-1:0]  word;
        bit                        typed;
        machine_result_t           res;
    } stim_row_t;

    typedef enum {STOP_HALT, STOP_DIVZ, STOP_BADOP, STOP_PAST_END} stop_kind_t;

    localparam machine_result_t ANY_RESULT = '{EV_DONE, 15'sd0, 7'd0};

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_command = CMD_LOAD;
    logic [PC_W-1:0]           in_address = '0;
    logic signed [WORD_W-1:0]  in_word = '0;
    logic                      out_stall = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [2:0]                o_event_res;
    logic signed [WORD_W-1:0]  o_value;
    logic [PC_W-1:0]           o_program_counter;

    // machine state as the testbench sees it
    logic signed [WORD_W-1:0]  mdl_store [STORE_WORDS] = '{default: '0};
    logic signed [WORD_W-1:0]  mdl_acc = '0;
    logic [PC_W-1:0]           mdl_pc = '0;
    bit                        mdl_stopped = 1'b0;

    machine_result_t           pending_results [$];
    int                        n_accepted = 0;
    int                        n_errors = 0;
    int                        idle_pct = 0;
    int                        stall_pct = 0;
    int                        quiet = 0;

    logic [6:0] run_ops [11] = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                                 OP_DIV, OP_MUL, OP_BRANCH, OP_BRNEG, OP_BRZERO};

    stim_row_t directed_rows [24] = '{
        '{CMD_LOAD, 7'd0,   15'sd2050,  1'b1, '{EV_DONE, 15'sd0, 7'd0}},
        '{CMD_LOAD, 7'd50,  15'sh3FFF,  1'b1, '{EV_DONE, 15'sd0, 7'd0}},
        '{CMD_LOAD, 7'd51,  15'sh4000,  1'b1, '{EV_DONE, 15'sd0, 7'd0}},
        // addresses past the store: drop the word
        '{CMD_LOAD, 7'd127, 15'sd1234,  1'b1, '{EV_DONE, 15'sd0, 7'd0}},
        '{CMD_LOAD, 7'd100, -15'sd1,    1'b1, '{EV_DONE, 15'sd0, 7'd0}},
        '{CMD_STEP, 7'd127, 15'sh4000,  1'b1, '{EV_DONE, 15'sd9999, 7'd1}},
        '{CMD_LOAD, 7'd1,   15'sd3050,  1'b1, '{EV_DONE, 15'sd9999, 7'd1}},
        '{CMD_STEP, 7'd0,   15'sd0,     1'b1, '{EV_OVF, 15'sd9999, 7'd2}},
        '{CMD_LOAD, 7'd2,   -15'sd3151, 1'b0, ANY_RESULT},
        '{CMD_STEP, 7'd0,   15'sd0,     1'b0, ANY_RESULT},
        '{CMD_LOAD, 7'd3,   15'sd3351,  1'b0, ANY_RESULT},
        '{CMD_STEP, 7'd0,   15'sd0,     1'b0, ANY_RESULT},
        '{CMD_LOAD, 7'd4,   15'sd1151,  1'b0, ANY_RESULT},
        '{CMD_STEP, 7'd0,   15'sd0,     1'b0, ANY_RESULT},
        '{CMD_LOAD, 7'd5,   15'sd1052,  1'b0, ANY_RESULT},
        '{CMD_STEP, 7'd0,   15'sh3FFF,  1'b0, ANY_RESULT},
        '{CMD_LOAD, 7'd6,   15'sd3252,  1'b0, ANY_RESULT},
        '{CMD_STEP, 7'd0,   15'sd0,     1'b0, ANY_RESULT},
        '{CMD_LOAD, 7'd7,   15'sd4120,  1'b0, ANY_RESULT},
        '{CMD_STEP, 7'd0,   15'sd0,     1'b0, ANY_RESULT},
        '{CMD_LOAD, 7'd20,  15'sd4230,  1'b0, ANY_RESULT},
        '{CMD_STEP, 7'd0,   15'sd0,     1'b0, ANY_RESULT},
        '{CMD_LOAD, 7'd21,  -15'sd4010, 1'b0, ANY_RESULT},
        '{CMD_STEP, 7'd0,   15'sd0,     1'b0, ANY_RESULT}
    };

    accumulator_machine_step #(
        .STORE_WORDS (STORE_WORDS)
    ) i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (in_command),
        .i_address         (in_address),
        .i_word            (in_word),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_event_res       (o_event_res),
        .o_value           (o_value),
        .o_program_counter (o_program_counter)
    );

    always #1 clk = ~clk;

    function automatic int saturate(input int v, inout bit ovf);
        if (v > WORD_MAX) begin
            ovf = 1'b1;
            return WORD_MAX;
        end
        if (v < -WORD_MAX) begin
            ovf = 1'b1;
            return -WORD_MAX;
        end
        return v;
    endfunction

    function automatic machine_result_t execute_item(input logic cmd,
                                                     input logic [PC_W-1:0] addr,
                                                     input logic signed [WORD_W-1:0] word);
        machine_result_t r;
        bit              ovf;
        int              w, ins, mag, loc, m, nxt;
        logic [6:0]      op;
        ovf = 1'b0;
        w = saturate(int'(word), ovf);
        ovf = 1'b0;
        m = 0;
        r.ev = EV_DONE;
        if (cmd == CMD_LOAD) begin
            if (addr < STORE_WORDS) mdl_store[addr] = WORD_W'(w);
        end else if (mdl_stopped) begin
            r.ev = EV_STOPPED;
        end else if (mdl_pc >= STORE_WORDS) begin
            mdl_stopped = 1'b1;
            r.ev = EV_HALT;
        end else begin
            ins = int'(mdl_store[mdl_pc]);
            mag = (ins < 0) ? -ins : ins;
            op  = 7'(mag / int'(RADIX));
            loc = mag % int'(RADIX);
            m   = (loc < STORE_WORDS) ? int'(mdl_store[loc]) : 0;
            nxt = int'(mdl_pc) + 1;
            case (op)
                OP_READ: begin
                    if (loc < STORE_WORDS) mdl_store[loc] = WORD_W'(w);
                end
                OP_WRITE:  r.ev = EV_WRITE;
                OP_LOAD:   mdl_acc = WORD_W'(m);
                OP_STORE: begin
                    if (loc < STORE_WORDS) mdl_store[loc] = mdl_acc;
                end
                OP_ADD:    mdl_acc = WORD_W'(saturate(int'(mdl_acc) + m, ovf));
                OP_SUB:    mdl_acc = WORD_W'(saturate(int'(mdl_acc) - m, ovf));
                OP_DIV: begin
                    if (m == 0) begin
                        mdl_stopped = 1'b1;
                        r.ev = EV_DIVZ;
                        nxt = int'(mdl_pc);
                    end else begin
                        mdl_acc = WORD_W'(saturate(int'(mdl_acc) / m, ovf));
                    end
                end
                OP_MUL:    mdl_acc = WORD_W'(saturate(int'(mdl_acc) * m, ovf));
                OP_BRANCH: nxt = loc;
                OP_BRNEG: begin
                    if (int'(mdl_acc) < 0) nxt = loc;
                end
                OP_BRZERO: begin
                    if (int'(mdl_acc) == 0) nxt = loc;
                end
                OP_HALT: begin
                    mdl_stopped = 1'b1;
                    r.ev = EV_HALT;
                    nxt = int'(mdl_pc);
                end
                default: begin
                    mdl_stopped = 1'b1;
                    r.ev = EV_BADOP;
                    nxt = int'(mdl_pc);
                end
            endcase
            if (ovf) r.ev = EV_OVF;
            mdl_pc = PC_W'(nxt);
        end
        r.value = (r.ev == EV_WRITE) ? WORD_W'(m) : mdl_acc;
        r.pc = mdl_pc;
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] op_word(input logic [6:0] op, input int loc);
        return WORD_W'(int'(op) * int'(RADIX) + loc);
    endfunction

    // Safe to run what sits at the pointer without stopping the machine?
    function automatic bit runnable();
        int         ins, mag, loc;
        logic [6:0] op;
        ins = int'(mdl_store[mdl_pc]);
        mag = (ins < 0) ? -ins : ins;
        op  = 7'(mag / int'(RADIX));
        loc = mag % int'(RADIX);
        if (mdl_pc >= TOP_PC) return (op == OP_BRANCH) && (loc < TOP_PC);
        if (op inside {OP_BRANCH, OP_BRNEG, OP_BRZERO}) return loc < TOP_PC;
        if (op == OP_DIV) return mdl_store[loc] != 0;
        return op inside {OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_MUL};
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_instruction(input int at);
        logic [6:0] op;
        int         loc;
        op  = (at >= TOP_PC) ? OP_BRANCH : run_ops[$urandom_range(0, 10)];
        loc = $urandom_range(0, STORE_WORDS - 1);
        if (op inside {OP_BRANCH, OP_BRNEG, OP_BRZERO}) loc = $urandom_range(0, TOP_PC - 1);
        if (op == OP_DIV && mdl_store[loc] == 0) op = OP_MUL;
        return $urandom_range(0, 1) ? -op_word(op, loc) : op_word(op, loc);
    endfunction

    function automatic logic signed [WORD_W-1:0] any_word();
        case ($urandom_range(0, 7))
            0:       return WORD_W'($urandom);
            1:       return $urandom_range(0, 1) ? WORD_W'(WORD_MAX) : WORD_W'(-WORD_MAX);
            2, 3:    return WORD_W'(int'($urandom_range(0, 40)) - 20);
            default: return WORD_W'(int'($urandom_range(0, 2 * WORD_MAX)) - WORD_MAX);
        endcase
    endfunction

    // Offer one item, wait for it to be taken, then record what it should produce.
    task automatic push_item(input logic cmd, input logic [PC_W-1:0] addr,
                             input logic signed [WORD_W-1:0] word,
                             input bit typed = 1'b0,
                             input machine_result_t typed_res = ANY_RESULT);
        machine_result_t r;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_address <= addr;
        in_word    <= word;
        do @(posedge clk); while (o_in_stall);
        r = execute_item(cmd, addr, word);
        if (typed) r = typed_res;
        pending_results.push_back(r);
        n_accepted++;
    endtask

    task automatic step_once(input bit keep);
        if (!runnable() || (!keep && $urandom_range(0, 2) == 0))
            push_item(CMD_LOAD, mdl_pc, pick_instruction(int'(mdl_pc)));
        push_item(CMD_STEP, 7'($urandom), any_word());
    endtask

    always @(posedge clk) begin : result_check
        machine_result_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no item outstanding");
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_event_res !== want.ev) begin
                        $error("event_res: expected %0d, got %0d", want.ev, o_event_res);
                        n_errors++;
                    end
                    if (o_value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, o_value);
                        n_errors++;
                    end
                    if (o_program_counter !== want.pc) begin
                        $error("program_counter: expected %0d, got %0d",
                               want.pc, o_program_counter);
                        n_errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet == WATCHDOG_LIMIT) begin
            $display("accumulator_machine_step: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int         act, burst, blk;
        logic [6:0] bad_op;
        blk = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            push_item(directed_rows[k].cmd, directed_rows[k].addr, directed_rows[k].word,
                      directed_rows[k].typed, directed_rows[k].res);

        while (n_accepted < $size(directed_rows) + RANDOM_ITEMS) begin
            if (n_accepted / PHASE_ITEMS != blk) begin
                blk = n_accepted / PHASE_ITEMS;
                case (blk % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 45; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 45; end
                    default: begin idle_pct = 7; stall_pct = 7; end
                endcase
                // hold the sender until the block has emptied
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end
            act = $urandom_range(0, 99);
            if (act < 8) begin
                push_item(CMD_LOAD, 7'($urandom), WORD_W'($urandom));
            end else if (act < 25) begin
                push_item(CMD_LOAD, 7'($urandom_range(0, STORE_WORDS - 1)), any_word());
            end else if (act < 45) begin
                // short straight program at the pointer, then run it
                burst = $urandom_range(2, 6);
                for (int j = 0; j < burst; j++)
                    push_item(CMD_LOAD, 7'(int'(mdl_pc) + j),
                              pick_instruction(int'(mdl_pc) + j));
                repeat (burst) step_once(1'b1);
            end else begin
                step_once(1'b0);
            end
        end

        // only reset clears the stopped flag, so stop the machine once, at the end
        idle_pct = 7;
        stall_pct = 7;
        case (stop_kind_t'($urandom_range(0, 3)))
            STOP_HALT: begin
                push_item(CMD_LOAD, mdl_pc, op_word(OP_HALT, $urandom_range(0, 99)));
            end
            STOP_DIVZ: begin
                push_item(CMD_LOAD, 7'(STORE_WORDS - 2), 15'sd0);
                push_item(CMD_LOAD, mdl_pc, -op_word(OP_DIV, STORE_WORDS - 2));
            end
            STOP_BADOP: begin
                do bad_op = 7'($urandom_range(0, 99));
                while (bad_op inside {OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                                      OP_DIV, OP_MUL, OP_BRANCH, OP_BRNEG, OP_BRZERO,
                                      OP_HALT});
                push_item(CMD_LOAD, mdl_pc, op_word(bad_op, $urandom_range(0, 99)));
            end
            default: begin
                // branch to the last word, run it, then step off the end
                push_item(CMD_LOAD, mdl_pc, op_word(OP_BRANCH, STORE_WORDS - 1));
                push_item(CMD_STEP, 7'($urandom), any_word());
                push_item(CMD_LOAD, 7'(STORE_WORDS - 1), op_word(OP_LOAD, $urandom_range(0, 99)));
                push_item(CMD_STEP, 7'($urandom), any_word());
            end
        endcase
        push_item(CMD_STEP, 7'($urandom), any_word());
        repeat (3) begin
            push_item(CMD_STEP, 7'($urandom), any_word());
            push_item(CMD_LOAD, 7'($urandom_range(0, STORE_WORDS - 1)), any_word());
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_errors == 0) begin
            $display("accumulator_machine_step: match");
        end else begin
            $display("accumulator_machine_step: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ams_pkg.sv
rtl/ams_ram.sv
rtl/ams_div.sv
rtl/ams_ctrl.sv
rtl/ams_dpath.sv
rtl/accumulator_machine_step.sv
tb/sv/testbench.sv
